// ===== sv/sbba_pkg.sv =====
// Shared types, constants and helpers for the session bitmap block allocator.
package sbba_pkg;

   localparam int NUM_BLOCKS_DEF = 4096;

   localparam int ADDR_FIELD_W  = 12;
   localparam int COUNT_FIELD_W = 13;
   localparam int STATUS_W      = 3;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 32;

   localparam logic [7:0] RESERVED_BYTE0 = 8'h07;
   localparam logic [7:0] FULL_BYTE      = 8'hff;

   typedef enum logic [1:0] {
      REQ_ALLOC       = 2'd0,
      REQ_FREE        = 2'd1,
      REQ_END_SESSION = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_FULL         = 3'd1,
      ST_BAD_ADDR     = 3'd2,
      ST_NOT_ALLOC    = 3'd3,
      ST_INCONSISTENT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LATCH,
      DP_INIT_WR,
      DP_SESS_WR,
      DP_KEEP,
      DP_BAD,
      DP_REL_RD,
      DP_REL_EV,
      DP_SCAN_START,
      DP_SCAN_RD,
      DP_SCAN_EV
   } dp_op_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_REL_RD,
      S_REL_EV,
      S_SCAN_INIT,
      S_SCAN_RD,
      S_SCAN_EV,
      S_SESS_CLR,
      S_DONE
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic         sweep_last;
      req_kind_type kind;
      logic         keep_hit;
      logic         free_old;
      logic         addr_zero;
      logic         addr_bad;
      logic         rel_used;
      logic         scan_hit;
      logic         scan_last;
      logic         rsp_free;
   } dp_stat_type;

   // position of the lowest clear bit of a byte (byte must not be all ones)
   function automatic logic [2:0] first_zero(input logic [7:0] v);
      logic [2:0] k;
      k = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!v[i]) begin
            k = 3'(i);
         end
      end
      return k;
   endfunction

endpackage

// ===== sv/session_bitmap_block_allocator.sv =====
// Top level of the session bitmap block allocator.
//
// Requests enter on the req_ stream (tuser = request kind, tdata = address
// and flags); one response item leaves on the rsp_ stream for each request.
// After reset an init pass writes the bitmap memories, one byte a cycle,
// with req_tready low. An end-session request runs the same pass over the
// session maps.
// Paths through the controller, from accept to response:
//   keep in place, bad address, free of zero, unknown kind: straight to done
//   free: bitmap read, then evaluate and write back
//   allocate: scan, after a release of the old address when free_old is set
// The scan reads one bitmap byte at a time through the registered memory
// read port, a read state then an evaluate state per byte; on a full table
// it visits every byte before it reports full.
// The response sits in an output register; a new request is taken while it
// waits, and the block stalls in its done state only if a second response
// is ready before the first is taken.
module session_bitmap_block_allocator #(
   parameter int NUM_BLOCKS = sbba_pkg::NUM_BLOCKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sbba_pkg::REQ_TDATA_W-1:0] req_tdata,  // block_address, keep_in_place, free_old
   input  logic [1:0]                       req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sbba_pkg::RSP_TDATA_W-1:0] rsp_tdata   // status, result_address, used_count
);

   sbba_pkg::dp_cmd_type  cmd;
   sbba_pkg::dp_stat_type stat;

   sbba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sbba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== sv/sbba_ctrl.sv =====
// Controller state machine of the block allocator.
module sbba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sbba_pkg::dp_stat_type stat,
   output sbba_pkg::dp_cmd_type  cmd
);

   sbba_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbba_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = sbba_pkg::DP_NOP;
      cmd.load_rsp = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         sbba_pkg::S_INIT: begin
            cmd.op = sbba_pkg::DP_INIT_WR;
            if (stat.sweep_last) begin
               state_in = sbba_pkg::S_IDLE;
            end
         end
         sbba_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = sbba_pkg::DP_LATCH;
               state_in = sbba_pkg::S_DECODE;
            end
         end
         sbba_pkg::S_DECODE: begin
            case (stat.kind)
               sbba_pkg::REQ_ALLOC: begin
                  if (stat.keep_hit) begin
                     cmd.op   = sbba_pkg::DP_KEEP;
                     state_in = sbba_pkg::S_DONE;
                  end else if (!stat.free_old || stat.addr_zero) begin
                     state_in = sbba_pkg::S_SCAN_INIT;
                  end else if (stat.addr_bad) begin
                     cmd.op   = sbba_pkg::DP_BAD;
                     state_in = sbba_pkg::S_DONE;
                  end else begin
                     state_in = sbba_pkg::S_REL_RD;
                  end
               end
               sbba_pkg::REQ_FREE: begin
                  if (stat.addr_zero) begin
                     state_in = sbba_pkg::S_DONE;
                  end else if (stat.addr_bad) begin
                     cmd.op   = sbba_pkg::DP_BAD;
                     state_in = sbba_pkg::S_DONE;
                  end else begin
                     state_in = sbba_pkg::S_REL_RD;
                  end
               end
               sbba_pkg::REQ_END_SESSION: begin
                  state_in = sbba_pkg::S_SESS_CLR;
               end
               default: begin
                  state_in = sbba_pkg::S_DONE;
               end
            endcase
         end
         sbba_pkg::S_REL_RD: begin
            cmd.op   = sbba_pkg::DP_REL_RD;
            state_in = sbba_pkg::S_REL_EV;
         end
         sbba_pkg::S_REL_EV: begin
            cmd.op = sbba_pkg::DP_REL_EV;
            if (stat.rel_used && stat.kind == sbba_pkg::REQ_ALLOC) begin
               state_in = sbba_pkg::S_SCAN_INIT;
            end else begin
               state_in = sbba_pkg::S_DONE;
            end
         end
         sbba_pkg::S_SCAN_INIT: begin
            cmd.op   = sbba_pkg::DP_SCAN_START;
            state_in = sbba_pkg::S_SCAN_RD;
         end
         sbba_pkg::S_SCAN_RD: begin
            cmd.op   = sbba_pkg::DP_SCAN_RD;
            state_in = sbba_pkg::S_SCAN_EV;
         end
         sbba_pkg::S_SCAN_EV: begin
            cmd.op = sbba_pkg::DP_SCAN_EV;
            if (stat.scan_hit || stat.scan_last) begin
               state_in = sbba_pkg::S_DONE;
            end else begin
               state_in = sbba_pkg::S_SCAN_RD;
            end
         end
         sbba_pkg::S_SESS_CLR: begin
            cmd.op = sbba_pkg::DP_SESS_WR;
            if (stat.sweep_last) begin
               state_in = sbba_pkg::S_DONE;
            end
         end
         sbba_pkg::S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = sbba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sbba_pkg::S_INIT;
         end
      endcase
   end

endmodule

// ===== sv/sbba_datapath.sv =====
// Datapath of the block allocator: bitmap memories, scan pointer, counters, result register.
module sbba_datapath #(
   parameter int NUM_BLOCKS = sbba_pkg::NUM_BLOCKS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [sbba_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sbba_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  sbba_pkg::dp_cmd_type                 cmd,
   output sbba_pkg::dp_stat_type                stat
);

   localparam int NUM_BYTES = NUM_BLOCKS / 8;
   localparam int BYTE_W    = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
   localparam int ADDR_W    = BYTE_W + 3;
   localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
   localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(NUM_BYTES - 1);

   logic [7:0]  used_mem [NUM_BYTES];
   logic [15:0] sess_mem [NUM_BYTES];  // {freed, alloc}

   logic [7:0]  used_rd_ff;
   logic [15:0] sess_rd_ff;

   sbba_pkg::req_kind_type kind_ff;
   logic [sbba_pkg::ADDR_FIELD_W-1:0] addr_ff;
   logic keep_ff, free_old_ff;

   logic [BYTE_W-1:0] sweep_ff, sweep_in;
   logic [BYTE_W-1:0] scan_byte_ff, scan_byte_in;
   logic [BYTE_W-1:0] scan_idx_ff, scan_idx_in;
   logic [BYTE_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]  used_total_ff, used_total_in;

   sbba_pkg::status_type status_ff, status_in;
   logic [sbba_pkg::ADDR_FIELD_W-1:0] res_addr_ff, res_addr_in;

   logic rsp_valid_ff, rsp_valid_in;
   sbba_pkg::status_type rsp_status_ff;
   logic [sbba_pkg::ADDR_FIELD_W-1:0]  rsp_addr_ff;
   logic [sbba_pkg::COUNT_FIELD_W-1:0] rsp_count_ff;

   logic [BYTE_W-1:0] rd_addr, wr_addr;
   logic              used_we, sess_we;
   logic [7:0]        used_wd;
   logic [15:0]       sess_wd;

   logic [ADDR_W-1:0] addr_blk;
   logic [BYTE_W-1:0] addr_byte;
   logic [2:0]        addr_bit, scan_bit;
   logic              scan_hit;

   assign addr_blk  = ADDR_W'(addr_ff);
   assign addr_byte = addr_blk[ADDR_W-1:3];
   assign addr_bit  = addr_ff[2:0];
   assign scan_hit  = used_rd_ff != sbba_pkg::FULL_BYTE;
   assign scan_bit  = sbba_pkg::first_zero(used_rd_ff);

   assign stat.sweep_last = sweep_ff == LAST_BYTE;
   assign stat.kind       = kind_ff;
   assign stat.keep_hit   = keep_ff && addr_ff != '0;
   assign stat.free_old   = free_old_ff;
   assign stat.addr_zero  = addr_ff == '0;
   assign stat.addr_bad   = 32'(addr_ff) >= 32'(NUM_BLOCKS);
   assign stat.rel_used   = used_rd_ff[addr_bit];
   assign stat.scan_hit   = scan_hit;
   assign stat.scan_last  = scan_cnt_ff == LAST_BYTE;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rd_addr = (cmd.op == sbba_pkg::DP_REL_RD) ? addr_byte : scan_idx_ff;

   always_ff @(posedge clock) begin
      used_rd_ff <= used_mem[rd_addr];
      sess_rd_ff <= sess_mem[rd_addr];
      if (used_we) begin
         used_mem[wr_addr] <= used_wd;
      end
      if (sess_we) begin
         sess_mem[wr_addr] <= sess_wd;
      end
   end

   always_comb begin
      wr_addr       = scan_idx_ff;
      used_we       = 1'b0;
      sess_we       = 1'b0;
      used_wd       = used_rd_ff;
      sess_wd       = sess_rd_ff;
      sweep_in      = sweep_ff;
      scan_byte_in  = scan_byte_ff;
      scan_idx_in   = scan_idx_ff;
      scan_cnt_in   = scan_cnt_ff;
      used_total_in = used_total_ff;
      status_in     = status_ff;
      res_addr_in   = res_addr_ff;
      case (cmd.op)
         sbba_pkg::DP_LATCH: begin
            status_in   = sbba_pkg::ST_OK;
            res_addr_in = '0;
         end
         sbba_pkg::DP_INIT_WR, sbba_pkg::DP_SESS_WR: begin
            wr_addr  = sweep_ff;
            sess_we  = 1'b1;
            sess_wd  = '0;
            used_we  = cmd.op == sbba_pkg::DP_INIT_WR;
            used_wd  = (sweep_ff == '0) ? sbba_pkg::RESERVED_BYTE0 : 8'h00;
            sweep_in = (sweep_ff == LAST_BYTE) ? '0 : sweep_ff + 1'b1;
         end
         sbba_pkg::DP_KEEP: begin
            res_addr_in = addr_ff;
         end
         sbba_pkg::DP_BAD: begin
            status_in = sbba_pkg::ST_BAD_ADDR;
         end
         sbba_pkg::DP_REL_EV: begin
            wr_addr = addr_byte;
            if (!used_rd_ff[addr_bit]) begin
               status_in = sbba_pkg::ST_NOT_ALLOC;
            end else if (sess_rd_ff[{1'b0, addr_bit}]) begin
               used_we                    = 1'b1;
               used_wd[addr_bit]          = 1'b0;
               sess_we                    = 1'b1;
               sess_wd[{1'b0, addr_bit}]  = 1'b0;
               if (used_total_ff != '0) begin
                  used_total_in = used_total_ff - 1'b1;
               end
            end else begin
               sess_we                    = 1'b1;
               sess_wd[{1'b1, addr_bit}]  = 1'b1;
            end
         end
         sbba_pkg::DP_SCAN_START: begin
            scan_idx_in = scan_byte_ff;
            scan_cnt_in = '0;
         end
         sbba_pkg::DP_SCAN_EV: begin
            if (scan_hit) begin
               if (sess_rd_ff[{1'b1, scan_bit}]) begin
                  status_in = sbba_pkg::ST_INCONSISTENT;
               end else begin
                  used_we                   = 1'b1;
                  used_wd[scan_bit]         = 1'b1;
                  sess_we                   = 1'b1;
                  sess_wd[{1'b0, scan_bit}] = 1'b1;
                  scan_byte_in              = scan_idx_ff;
                  used_total_in             = used_total_ff + 1'b1;
                  res_addr_in = sbba_pkg::ADDR_FIELD_W'({scan_idx_ff, scan_bit});
               end
            end else begin
               scan_idx_in = (scan_idx_ff == LAST_BYTE) ? '0 : scan_idx_ff + 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
               if (scan_cnt_ff == LAST_BYTE) begin
                  status_in = sbba_pkg::ST_FULL;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= '0;
         scan_byte_ff  <= '0;
         used_total_ff <= CNT_W'(3);
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         scan_byte_ff  <= scan_byte_in;
         used_total_ff <= used_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      scan_cnt_ff <= scan_cnt_in;
      status_ff   <= status_in;
      res_addr_ff <= res_addr_in;
      if (cmd.op == sbba_pkg::DP_LATCH) begin
         kind_ff     <= sbba_pkg::req_kind_type'(req_tuser);
         addr_ff     <= req_tdata[11:0];
         keep_ff     <= req_tdata[12];
         free_old_ff <= req_tdata[13];
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_count_ff  <= sbba_pkg::COUNT_FIELD_W'(used_total_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_addr_ff, rsp_status_ff};

endmodule

// ===== sv/sbba_checker.sv =====
// Port-level checker for the block allocator, bound to the top level.
module sbba_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [sbba_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [1:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sbba_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response item changed while stalled");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != sbba_pkg::ST_OK |-> rsp_tdata[14:3] == '0)
      else $error("failed request returned an address");

   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request taken during init pass");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared one cycle after request");

endmodule

bind session_bitmap_block_allocator sbba_checker u_sbba_checker (.*);
